FILE: rtl/stream_find_replace_macros.svh
// Assertion macros used by the stream find and replace checker.
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sfr_pkg.sv
// Types and constants for the stream find and replace block.
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int REPL_MAX   = 8;
  localparam int REPL_IDX_W = 3;
  localparam int EMIT_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 4'd3;

  // Source of one emitted result
  localparam logic [1:0] KIND_POP    = 2'd0;
  localparam logic [1:0] KIND_REPL   = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;

  typedef struct packed {
    logic       insert;
    logic       clear;
    logic       emit;
    logic [1:0] kind;
    logic       emit_last;
  } sfr_cmd_t;

  typedef struct packed {
    logic [EMIT_W-1:0] count;
    logic              match;
    logic              marker;
    logic              last;
    logic              out_free;
  } sfr_status_t;

endpackage

FILE: rtl/stream_find_replace.sv
// Top level of the streaming find and replace block.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  s_*      | s_tvalid / s_tready   | s_tdata = in_byte, s_tlast = in_last
//  m_*      | m_tvalid / m_tready   | m_tdata = out_byte, m_tuser = out_valid,
//           |                       | m_tlast = out_last
//  cfg_*    | cfg_valid / cfg_ready | cfg_index = register, cfg_data = value
//
// Each input byte goes through the insert and evaluate states, then emits 0 to 8
// results; the single output register sets the emit pace.
// Output stalls hold the sequencer in its emit state; the input stays blocked until
// the last result of the byte is in the output register.
// rst is synchronous and clears window count, sequencer and config registers.
// cfg_ready is always high.
`timescale 1ns / 1ps
module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] in_byte
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] out_byte
  output logic [0:0]            m_tuser,   // [0] out_valid
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sfr_cmd_t    cmd;
  sfr_status_t status;

  assign cfg_ready = 1'b1;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: rtl/sfr_ctrl.sv
// Sequencer: takes one byte, plans its results, then emits them one per free slot.
`timescale 1ns / 1ps
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  sfr_status_t status,
  output sfr_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state, state_next;
  logic [EMIT_W-1:0] remaining, remaining_next;
  logic [1:0]        kind, kind_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    kind_next      = kind;
    cmd            = '0;
    cmd.kind       = kind;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.insert = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        remaining_next = status.count;
        cmd.clear      = status.match;
        if (status.marker) begin
          kind_next = KIND_MARKER;
        end else if (status.match) begin
          kind_next = KIND_REPL;
        end else begin
          kind_next = KIND_POP;
        end
        state_next = (status.count == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_last  = status.last && (remaining == EMIT_W'(1));
          remaining_next = remaining - EMIT_W'(1);
          if (remaining == EMIT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
      kind      <= KIND_POP;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
      kind      <= kind_next;
    end
  end

endmodule

FILE: rtl/sfr_datapath.sv
// Window shift register, pattern compare, config registers and output register.
`timescale 1ns / 1ps
module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sfr_cmd_t              cmd,
  output sfr_status_t           status,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tlast,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [7:0]            m_tdata,
  output logic [0:0]            m_tuser,
  output logic                  m_tlast
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [CFG_DATA_W-1:0] pattern_bytes, replacement_bytes;
  logic [LEN_W-1:0]      pattern_length, replacement_length;

  logic [BYTE_W-1:0]     win [MAX_PATTERN];
  logic [CW-1:0]         wc;
  logic [CW-1:0]         wc_ins;
  logic                  last_item;
  logic [REPL_IDX_W-1:0] repl_idx;

  logic [LEN_W-1:0]      plen_c, rlen_c, wc_l;
  logic                  mismatch;
  logic [EMIT_W-1:0]     pop_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate lengths to the window depth and the replacement size
  assign plen_c = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : pattern_length;
  assign rlen_c = (replacement_length > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX)
                                                           : replacement_length;
  assign wc_l   = LEN_W'(wc);
  assign wc_ins = (wc >= CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN - 1) : wc;

  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < plen_c) && (win[i] != pattern_bytes[i*BYTE_W +: BYTE_W])) begin
        mismatch = 1'b1;
      end
    end
  end

  // drain one or two bytes while the window is at least as long as the pattern
  always_comb begin
    if (wc_l > plen_c) begin
      pop_cnt = ((wc_l - LEN_W'(1)) > plen_c) ? EMIT_W'(2) : EMIT_W'(1);
    end else if (wc_l == plen_c) begin
      pop_cnt = EMIT_W'(1);
    end else begin
      pop_cnt = '0;
    end
  end

  always_comb begin
    status.match    = (wc_l == plen_c) && !mismatch;
    status.marker   = status.match && last_item && (rlen_c == '0);
    status.last     = last_item;
    status.out_free = !m_tvalid || m_tready;
    if (status.match) begin
      status.count = status.marker ? EMIT_W'(1) : EMIT_W'(rlen_c);
    end else if (last_item) begin
      status.count = EMIT_W'(wc_l);
    end else begin
      status.count = pop_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (wc_ins == CW'(i)) begin
          win[i] <= s_tdata;
        end
      end
    end else if (cmd.emit && (cmd.kind == KIND_POP)) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc        <= '0;
      last_item <= 1'b0;
      repl_idx  <= '0;
    end else begin
      if (cmd.insert) begin
        wc        <= wc_ins + CW'(1);
        last_item <= s_tlast;
        repl_idx  <= '0;
      end else if (cmd.clear) begin
        wc <= '0;
      end else if (cmd.emit && (cmd.kind == KIND_POP)) begin
        wc <= wc - CW'(1);
      end
      if (cmd.emit && (cmd.kind == KIND_REPL)) begin
        repl_idx <= repl_idx + REPL_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tlast <= cmd.emit_last;
      case (cmd.kind)
        KIND_POP: begin
          m_tdata <= win[0];
          m_tuser <= 1'b1;
        end
        KIND_REPL: begin
          m_tdata <= replacement_bytes[{repl_idx, 3'b000} +: BYTE_W];
          m_tuser <= 1'b1;
        end
        default: begin
          m_tdata <= '0;
          m_tuser <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sfr_checker.sv
// Port-level checks for the stream find and replace block, bound to the top level.
`timescale 1ns / 1ps
`include "stream_find_replace_macros.svh"
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser,
  input logic       m_tlast
);

  // a transfer blocks the input while its results are planned
  `SFR_ASSERT_NEXT(a_in_busy_after_transfer, s_tvalid && s_tready, !s_tready, "input ready right after a transfer")

  // the end marker only closes a stream and carries a zero byte
  `SFR_ASSERT_NOW(a_marker_is_last, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == 8'd0), "end marker malformed")

  `SFR_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "output valid dropped under stall")

  `SFR_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "output payload changed under stall")

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
